/* rtl/core/fmd_pkg.sv */
// Shared types and constants for the flood mesh header engine.
package fmd_pkg;

    typedef enum logic [2:0] {
        V_MALFORMED     = 3'd0,
        V_BAD_CRC       = 3'd1,
        V_DUPLICATE     = 3'd2,
        V_DELIVERED     = 3'd3,
        V_TTL_EXPIRED   = 3'd4,
        V_FORWARD       = 3'd5,
        V_FRAGMENT      = 3'd6,
        V_SEND_REJECTED = 3'd7
    } verdict_t;

    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_SEND    = 1'b1;

    localparam logic [7:0] SEND_TTL = 8'd6;
    localparam int RESULT_LIMIT = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // One classified item on its way from front to back
    typedef struct packed {
        verdict_t    verdict;
        logic [7:0]  src;
        logic [7:0]  dst;
        logic [7:0]  msg_id;
        logic [7:0]  ttl;
        logic [7:0]  frag_index;
        logic [7:0]  frag_total;
        logic [15:0] len;
        logic [2:0]  nfrag;
    } cmd_t;

endpackage

/* rtl/core/fmd_queue.sv */
// Small command FIFO between classifier and result sequencer.
module fmd_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fmd_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output fmd_pkg::cmd_t head,
    output logic          empty
);

    fmd_pkg::cmd_t mem_reg [fmd_pkg::QUEUE_DEPTH];
    logic [fmd_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fmd_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fmd_pkg::QPTR_W:0]   count_reg, count_next;

    assign full  = (count_reg == (fmd_pkg::QPTR_W+1)'(fmd_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/core/fmd_front.sv */
// Front end: header checks, seen-list lookup and update, send splitting.
module fmd_front
#(
    parameter int SEEN_DEPTH    = 32,
    parameter int PAYLOAD_MAX   = 64,
    parameter int MAX_FRAGMENTS = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    node_id,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          operation,
    input  logic [7:0]    src_node,
    input  logic [7:0]    dst_node,
    input  logic [7:0]    msg_id,
    input  logic [7:0]    hop_ttl,
    input  logic [7:0]    frag_index,
    input  logic [7:0]    frag_total,
    input  logic [15:0]   payload_len,
    input  logic          crc_ok,
    input  logic          q_full,
    output logic          push,
    output fmd_pkg::cmd_t cmd
);

    localparam int FRAG_LIMIT = (MAX_FRAGMENTS < fmd_pkg::RESULT_LIMIT) ?
                                MAX_FRAGMENTS : fmd_pkg::RESULT_LIMIT;
    localparam int FILL_W = $clog2(SEEN_DEPTH + 1);
    localparam int IDX_W  = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;

    logic [15:0]       keys_reg [SEEN_DEPTH];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        id_reg, id_next;

    logic [15:0] key;
    logic        hit;
    logic        malformed;
    logic [2:0]  nfrag;
    logic        reject;
    logic        record;
    logic        accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept;

    assign key = (operation == fmd_pkg::OP_SEND) ? {node_id, id_reg} : {src_node, msg_id};

    // parallel compare over the live part of the seen list
    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < SEEN_DEPTH; i++)
        begin
            if ((FILL_W'(i) < fill_reg) && (keys_reg[i] == key))
            begin
                hit = 1'b1;
            end
        end
    end

    assign malformed = ({16'd0, payload_len} > 32'(PAYLOAD_MAX)) ||
                       (frag_index >= frag_total) ||
                       ({24'd0, frag_total} > 32'(FRAG_LIMIT));

    // fragment count: how many fragment boundaries the length passes
    always_comb
    begin
        nfrag = '0;
        for (int k = 0; k <= fmd_pkg::RESULT_LIMIT; k++)
        begin
            if ({16'd0, payload_len} > 32'(k * PAYLOAD_MAX))
            begin
                nfrag = nfrag + 3'd1;
            end
        end
    end

    assign reject = (nfrag == 3'd0) || (32'(nfrag) > 32'(FRAG_LIMIT));

    always_comb
    begin
        if (operation == fmd_pkg::OP_SEND)
        begin
            record = !reject && !hit;
        end
        else
        begin
            record = !malformed && crc_ok && !hit;
        end
    end

    always_comb
    begin
        cmd            = '0;
        cmd.verdict    = fmd_pkg::V_MALFORMED;
        cmd.nfrag      = 3'd1;
        if (operation == fmd_pkg::OP_SEND)
        begin
            if (reject)
            begin
                cmd.verdict = fmd_pkg::V_SEND_REJECTED;
            end
            else
            begin
                cmd.verdict    = fmd_pkg::V_FRAGMENT;
                cmd.src        = node_id;
                cmd.dst        = dst_node;
                cmd.msg_id     = id_reg;
                cmd.ttl        = fmd_pkg::SEND_TTL;
                cmd.frag_total = {5'd0, nfrag};
                cmd.len        = payload_len;
                cmd.nfrag      = nfrag;
            end
        end
        else if (malformed)
        begin
            cmd.verdict = fmd_pkg::V_MALFORMED;
        end
        else if (!crc_ok)
        begin
            cmd.verdict = fmd_pkg::V_BAD_CRC;
        end
        else if (hit)
        begin
            cmd.verdict = fmd_pkg::V_DUPLICATE;
        end
        else if (dst_node == node_id)
        begin
            cmd.verdict = fmd_pkg::V_DELIVERED;
        end
        else if (hop_ttl == 8'd0)
        begin
            cmd.verdict = fmd_pkg::V_TTL_EXPIRED;
        end
        else
        begin
            cmd.verdict    = fmd_pkg::V_FORWARD;
            cmd.src        = src_node;
            cmd.dst        = dst_node;
            cmd.msg_id     = msg_id;
            cmd.ttl        = hop_ttl - 8'd1;
            cmd.frag_index = frag_index;
            cmd.frag_total = frag_total;
            cmd.len        = payload_len;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        id_next   = id_reg;
        if (accept && record && (fill_reg < FILL_W'(SEEN_DEPTH)))
        begin
            fill_next = fill_reg + 1'b1;
        end
        if (accept && (operation == fmd_pkg::OP_SEND) && !reject)
        begin
            id_next = id_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            id_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            id_reg   <= id_next;
        end
    end

    // append while not full, else drop the oldest and append at the end
    always_ff @(posedge clk)
    begin
        if (accept && record)
        begin
            if (fill_reg < FILL_W'(SEEN_DEPTH))
            begin
                keys_reg[fill_reg[IDX_W-1:0]] <= key;
            end
            else
            begin
                for (int i = 0; i < SEEN_DEPTH - 1; i++)
                begin
                    keys_reg[i] <= keys_reg[i+1];
                end
                keys_reg[SEEN_DEPTH-1] <= key;
            end
        end
    end

endmodule

/* rtl/core/fmd_back.sv */
// Back end: result sequencing, fragment lengths, counters, output register.
module fmd_back
#(
    parameter int PAYLOAD_MAX = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  fmd_pkg::cmd_t head,
    input  logic          q_empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [2:0]    verdict,
    output logic [7:0]    out_src,
    output logic [7:0]    out_dst,
    output logic [7:0]    out_msg_id,
    output logic [7:0]    out_ttl,
    output logic [7:0]    out_frag_index,
    output logic [7:0]    out_frag_total,
    output logic [15:0]   out_len,
    output logic          last_result,
    output logic [31:0]   dup_count,
    output logic [31:0]   delivered_count,
    output logic [31:0]   forward_count
);

    logic        emit;
    logic        is_frag;
    logic        last;
    logic [15:0] cur_left;
    logic [15:0] flen;

    logic [2:0]  frag_i_reg, frag_i_next;
    logic [15:0] left_reg;
    logic [31:0] dup_reg, dup_next;
    logic [31:0] del_reg, del_next;
    logic [31:0] fwd_reg, fwd_next;
    logic        valid_reg, valid_next;

    logic [2:0]  verdict_reg;
    logic [7:0]  src_reg, dst_reg, id_reg, ttl_reg, fi_reg, ft_reg;
    logic [15:0] len_reg;
    logic        last_reg;
    logic [31:0] dupo_reg, delo_reg, fwdo_reg;

    assign emit     = !q_empty && (!valid_reg || out_ready);
    assign is_frag  = (head.verdict == fmd_pkg::V_FRAGMENT);
    assign last     = !is_frag || ((frag_i_reg + 3'd1) == head.nfrag);
    assign pop      = emit && last;
    assign cur_left = (frag_i_reg == 3'd0) ? head.len : left_reg;
    assign flen     = ({16'd0, cur_left} > 32'(PAYLOAD_MAX)) ? 16'(PAYLOAD_MAX) : cur_left;

    always_comb
    begin
        frag_i_next = frag_i_reg;
        dup_next    = dup_reg;
        del_next    = del_reg;
        fwd_next    = fwd_reg;
        valid_next  = valid_reg;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        if (emit)
        begin
            valid_next  = 1'b1;
            frag_i_next = last ? 3'd0 : frag_i_reg + 3'd1;
            case (head.verdict)
                fmd_pkg::V_DUPLICATE: dup_next = dup_reg + 32'd1;
                fmd_pkg::V_DELIVERED: del_next = del_reg + 32'd1;
                fmd_pkg::V_FORWARD:   fwd_next = fwd_reg + 32'd1;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frag_i_reg <= '0;
            dup_reg    <= '0;
            del_reg    <= '0;
            fwd_reg    <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            frag_i_reg <= frag_i_next;
            dup_reg    <= dup_next;
            del_reg    <= del_next;
            fwd_reg    <= fwd_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            left_reg    <= cur_left - 16'(PAYLOAD_MAX);
            verdict_reg <= head.verdict;
            src_reg     <= head.src;
            dst_reg     <= head.dst;
            id_reg      <= head.msg_id;
            ttl_reg     <= head.ttl;
            fi_reg      <= is_frag ? {5'd0, frag_i_reg} : head.frag_index;
            ft_reg      <= head.frag_total;
            len_reg     <= is_frag ? flen : head.len;
            last_reg    <= last;
            dupo_reg    <= dup_next;
            delo_reg    <= del_next;
            fwdo_reg    <= fwd_next;
        end
    end

    assign out_valid       = valid_reg;
    assign verdict         = verdict_reg;
    assign out_src         = src_reg;
    assign out_dst         = dst_reg;
    assign out_msg_id      = id_reg;
    assign out_ttl         = ttl_reg;
    assign out_frag_index  = fi_reg;
    assign out_frag_total  = ft_reg;
    assign out_len         = len_reg;
    assign last_result     = last_reg;
    assign dup_count       = dupo_reg;
    assign delivered_count = delo_reg;
    assign forward_count   = fwdo_reg;

`ifndef SYNTHESIS
    a_dup_only_on_dup: assert property (@(posedge clk) disable iff (!rst_n)
        !(emit && (head.verdict == fmd_pkg::V_DUPLICATE)) |=> $stable(dup_reg))
        else $error("duplicate counter moved without a duplicate result");
    a_frag_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_empty && is_frag) |-> (frag_i_reg < head.nfrag))
        else $error("fragment index ran past fragment count");
    a_nonfrag_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (verdict_reg != fmd_pkg::V_FRAGMENT)) |-> last_reg)
        else $error("single-result verdict without last flag");
    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> (frag_i_reg == 3'd0))
        else $error("fragment index left nonzero with empty queue");
`endif

endmodule

/* rtl/core/flood_mesh_dedup_forward_engine.sv */
// Top level of the flood mesh header engine: config register, front, queue, back.
//
// Header engine for a flooding mesh node. Each input transfer is either a
// received frame header (s_tuser = 0) or a send request (s_tuser = 1). The
// front end classifies it in the cycle it is taken: malformed, bad CRC,
// duplicate (parallel compare against a FIFO seen-list of SEEN_DEPTH keys
// src:msgid, oldest dropped when full), delivered, TTL expired or forward;
// a send is split into up to four fragment headers or rejected. Classified items
// wait in a four-entry queue, so input stays open while results stall until it is
// full. While items wait and the output is not stalled, the back end emits one
// result transfer per cycle: one for a received frame or a rejected send, one per
// fragment for a send, so an item yields 1 to 4 results. The result carries the
// duplicate, delivered and forwarded counters after its own update. The user must
// write node_id through the cfg channel only while idle; no logic enforces it.
module flood_mesh_dedup_forward_engine
#(
    parameter int SEEN_DEPTH    = 32,
    parameter int PAYLOAD_MAX   = 64,
    parameter int MAX_FRAGMENTS = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data,     // node_id
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,      // src_node, dst_node, msg_id, hop_ttl,
                                       // frag_index, frag_total, payload_len, crc_ok
    input  logic         s_tuser,      // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,      // out_src, out_dst, out_msg_id, out_ttl,
                                       // out_frag_index, out_frag_total, out_len,
                                       // dup_count, delivered_count, forward_count
    output logic [2:0]   m_tuser,      // verdict
    output logic         m_tlast       // last_result
);

    logic [7:0] node_id_reg;

    fmd_pkg::cmd_t front_cmd;
    fmd_pkg::cmd_t head_cmd;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    logic [7:0]  out_src, out_dst, out_msg_id, out_ttl, out_frag_index, out_frag_total;
    logic [15:0] out_len;
    logic [31:0] dup_count, delivered_count, forward_count;

    // config is always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg <= '0;
        end
        else if (cfg_valid)
        begin
            node_id_reg <= cfg_data;
        end
    end

    fmd_front
    #(
        .SEEN_DEPTH    (SEEN_DEPTH),
        .PAYLOAD_MAX   (PAYLOAD_MAX),
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    )
    u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .node_id     (node_id_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .operation   (s_tuser),
        .src_node    (s_tdata[7:0]),
        .dst_node    (s_tdata[15:8]),
        .msg_id      (s_tdata[23:16]),
        .hop_ttl     (s_tdata[31:24]),
        .frag_index  (s_tdata[39:32]),
        .frag_total  (s_tdata[47:40]),
        .payload_len (s_tdata[63:48]),
        .crc_ok      (s_tdata[64]),
        .q_full      (q_full),
        .push        (push),
        .cmd         (front_cmd)
    );

    fmd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (head_cmd),
        .empty    (q_empty)
    );

    fmd_back
    #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    )
    u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head_cmd),
        .q_empty         (q_empty),
        .pop             (pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .verdict         (m_tuser),
        .out_src         (out_src),
        .out_dst         (out_dst),
        .out_msg_id      (out_msg_id),
        .out_ttl         (out_ttl),
        .out_frag_index  (out_frag_index),
        .out_frag_total  (out_frag_total),
        .out_len         (out_len),
        .last_result     (m_tlast),
        .dup_count       (dup_count),
        .delivered_count (delivered_count),
        .forward_count   (forward_count)
    );

    assign m_tdata = {forward_count, delivered_count, dup_count, out_len,
                      out_frag_total, out_frag_index, out_ttl, out_msg_id,
                      out_dst, out_src};

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the flood mesh header engine: stream driver, monitor and predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int SEEN_DEPTH   = 32;
    localparam int PAYLOAD_MAX  = 64;
    localparam int FRAG_LIMIT   = 4;
    localparam int SETTLE_CYC   = 20;   // back end drains a few results after the queue empties
    localparam int STALL_LIMIT  = 4000; // cycles with no transfer before giving up

    // one header or send request as the sender sees it
    typedef struct {
        logic        op;
        logic [7:0]  src;
        logic [7:0]  dst;
        logic [7:0]  mid;
        logic [7:0]  ttl;
        logic [7:0]  fi;
        logic [7:0]  ft;
        logic [15:0] len;
        logic        crc;
    } hdr_item_t;

    // one header result with the counters after its update
    typedef struct {
        fmd_pkg::verdict_t verdict;
        logic [7:0]  src;
        logic [7:0]  dst;
        logic [7:0]  mid;
        logic [7:0]  ttl;
        logic [7:0]  fi;
        logic [7:0]  ft;
        logic [15:0] len;
        logic        last;
        logic [31:0] dups;
        logic [31:0] delivered;
        logic [31:0] forwarded;
    } hdr_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [7:0]   cfg_data = 8'd0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    flood_mesh_dedup_forward_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor state: own copy of node address, seen list and counters
    // ---------------------------------------------------------------
    logic [7:0]    node_addr = 8'd0;
    logic [15:0]   seen_list[$];
    logic [7:0]    next_msg = 8'd0;
    logic [31:0]   dup_total = 32'd0;
    logic [31:0]   dlv_total = 32'd0;
    logic [31:0]   fwd_total = 32'd0;

    hdr_item_t     pending_items[$];   // filled by the stimulus block, drained by the driver
    hdr_result_t   expected_hdrs[$];   // predicted results, oldest first
    hdr_item_t     on_bus;             // item currently presented on the slave side
    logic          in_taken = 1'b0;
    int            cyc = 0;
    int            idle_cyc = 0;
    int            errors = 0;

    function automatic bit key_seen(logic [15:0] key);
        foreach (seen_list[i])
            if (seen_list[i] == key)
                return 1'b1;
        return 1'b0;
    endfunction

    // FIFO seen list: a full list drops its oldest key
    function automatic void key_remember(logic [15:0] key);
        if (key_seen(key))
            return;
        if (seen_list.size() >= SEEN_DEPTH)
            void'(seen_list.pop_front());
        seen_list.push_back(key);
    endfunction

    function automatic hdr_result_t status_only(fmd_pkg::verdict_t v);
        hdr_result_t r;
        r = '{verdict: v, last: 1'b1, dups: dup_total, delivered: dlv_total,
              forwarded: fwd_total, default: '0};
        return r;
    endfunction

    // Classify one accepted item and queue the headers it must produce
    function automatic void classify_item(hdr_item_t it);
        hdr_result_t r;
        logic [15:0] key;
        int          nfrag;
        int          left;
        if (it.op == fmd_pkg::OP_RECEIVE)
        begin
            key = {it.src, it.mid};
            if (it.len > PAYLOAD_MAX || it.fi >= it.ft || it.ft > FRAG_LIMIT)
                expected_hdrs.push_back(status_only(fmd_pkg::V_MALFORMED));
            else if (!it.crc)
                expected_hdrs.push_back(status_only(fmd_pkg::V_BAD_CRC));
            else if (key_seen(key))
            begin
                dup_total++;
                expected_hdrs.push_back(status_only(fmd_pkg::V_DUPLICATE));
            end
            else
            begin
                key_remember(key);
                if (it.dst == node_addr)
                begin
                    dlv_total++;
                    expected_hdrs.push_back(status_only(fmd_pkg::V_DELIVERED));
                end
                else if (it.ttl == 8'd0)
                    expected_hdrs.push_back(status_only(fmd_pkg::V_TTL_EXPIRED));
                else
                begin
                    fwd_total++;
                    r = status_only(fmd_pkg::V_FORWARD);
                    r.src = it.src;
                    r.dst = it.dst;
                    r.mid = it.mid;
                    r.ttl = it.ttl - 8'd1;
                    r.fi  = it.fi;
                    r.ft  = it.ft;
                    r.len = it.len;
                    expected_hdrs.push_back(r);
                end
            end
        end
        else
        begin
            nfrag = (int'(it.len) + PAYLOAD_MAX - 1) / PAYLOAD_MAX;
            if (nfrag < 1 || nfrag > FRAG_LIMIT)
                expected_hdrs.push_back(status_only(fmd_pkg::V_SEND_REJECTED));
            else
            begin
                key_remember({node_addr, next_msg});
                for (int i = 0; i < nfrag; i++)
                begin
                    left = int'(it.len) - i * PAYLOAD_MAX;
                    r = status_only(fmd_pkg::V_FRAGMENT);
                    r.src  = node_addr;
                    r.dst  = it.dst;
                    r.mid  = next_msg;
                    r.ttl  = fmd_pkg::SEND_TTL;
                    r.fi   = 8'(i);
                    r.ft   = 8'(nfrag);
                    r.len  = 16'((left > PAYLOAD_MAX) ? PAYLOAD_MAX : left);
                    r.last = (i + 1 == nfrag);
                    expected_hdrs.push_back(r);
                end
                next_msg++;
            end
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t mismatch %s: expected %0h, actual %0h", $realtime, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // ---------------------------------------------------------------
    // Idling: ~6% random gaps on each side, none in one long window
    // ---------------------------------------------------------------
    function automatic bit take_break();
        if (cyc >= 1500 && cyc < 3500)
            return 1'b0;
        return $urandom_range(99) < 6;
    endfunction

    // Driver: presents the next pending item at the falling edge
    always @(negedge clk)
    begin
        hdr_item_t nxt;
        logic      drive;
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                drive = (pending_items.size() != 0) && !take_break();
                if (drive)
                begin
                    nxt = pending_items.pop_front();
                    on_bus <= nxt;
                    s_tdata <= {7'd0, nxt.crc, nxt.len, nxt.ft, nxt.fi, nxt.ttl,
                                nxt.mid, nxt.dst, nxt.src};
                    s_tuser <= nxt.op;
                end
                s_tvalid <= drive;
            end
            m_tready <= !take_break();
        end
    end

    // Monitor: transfers are taken at the rising edge
    always @(posedge clk)
    begin
        hdr_result_t e;
        cyc <= cyc + 1;
        in_taken <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
            classify_item(on_bus);
        if (cfg_valid && cfg_ready)
            node_addr = cfg_data;
        if (m_tvalid && m_tready)
        begin
            if (expected_hdrs.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual verdict %0d",
                         $realtime, m_tuser);
                errors++;
            end
            else
            begin
                e = expected_hdrs.pop_front();
                check_field("verdict",    e.verdict,   m_tuser);
                check_field("out_src",    e.src,       m_tdata[7:0]);
                check_field("out_dst",    e.dst,       m_tdata[15:8]);
                check_field("out_msg_id", e.mid,       m_tdata[23:16]);
                check_field("out_ttl",    e.ttl,       m_tdata[31:24]);
                check_field("frag_index", e.fi,        m_tdata[39:32]);
                check_field("frag_total", e.ft,        m_tdata[47:40]);
                check_field("out_len",    e.len,       m_tdata[63:48]);
                check_field("dup_count",  e.dups,      m_tdata[95:64]);
                check_field("delivered",  e.delivered, m_tdata[127:96]);
                check_field("forwarded",  e.forwarded, m_tdata[159:128]);
                check_field("last",       e.last,      m_tlast);
            end
        end
        // watchdog on cycles with no transfer anywhere
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic hdr_item_t rx_item(logic [7:0] src, logic [7:0] dst, logic [7:0] mid,
                                          logic [7:0] ttl, logic [7:0] fi, logic [7:0] ft,
                                          logic [15:0] len, logic crc);
        hdr_item_t it;
        it = '{op: fmd_pkg::OP_RECEIVE, src: src, dst: dst, mid: mid, ttl: ttl, fi: fi,
               ft: ft, len: len, crc: crc};
        return it;
    endfunction

    function automatic hdr_item_t tx_item(logic [7:0] dst, logic [15:0] len);
        hdr_item_t it;
        it = '{op: fmd_pkg::OP_SEND, dst: dst, len: len, src: 8'($urandom),
               mid: 8'($urandom), ttl: 8'($urandom), fi: 8'($urandom), ft: 8'($urandom),
               crc: 1'($urandom)};
        return it;
    endfunction

    // Mostly well-formed headers over a small key space so duplicates and
    // seen-list eviction both happen; some sends and some raw noise.
    function automatic hdr_item_t random_item(logic [7:0] addr);
        hdr_item_t   it;
        int          pick;
        logic [7:0]  ft;
        logic [15:0] len;
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            it = '{op: 1'($urandom), src: 8'($urandom), dst: 8'($urandom),
                   mid: 8'($urandom), ttl: 8'($urandom), fi: 8'($urandom),
                   ft: 8'($urandom), len: 16'($urandom), crc: 1'($urandom)};
            return it;
        end
        if (pick < 32)
        begin
            case ($urandom_range(9))
                0:       len = 16'd0;
                1:       len = 16'($urandom_range(65535, 257));
                default: len = 16'($urandom_range(256, 1));
            endcase
            return tx_item(($urandom_range(3) == 0) ? addr : 8'($urandom), len);
        end
        ft = 8'($urandom_range(FRAG_LIMIT, 1));
        len = ($urandom_range(9) == 0) ? 16'(PAYLOAD_MAX) : 16'($urandom_range(PAYLOAD_MAX));
        return rx_item(($urandom_range(7) == 0) ? addr : 8'($urandom_range(5) * 51),
                       ($urandom_range(3) == 0) ? addr : 8'($urandom),
                       ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(7)),
                       ($urandom_range(6) == 0) ? 8'd0 : 8'($urandom),
                       8'($urandom_range(ft - 1)), ft, len,
                       $urandom_range(11) != 0);
    endfunction

    task automatic write_node(logic [7:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || s_tvalid || expected_hdrs.size() != 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    logic [7:0] phase_addr[4] = '{8'd255, 8'd0, 8'd1, 8'd0};

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_node(8'd0);

        // directed: every verdict, field extremes, send boundaries
        pending_items.push_back(rx_item(8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 8'd1, 16'd65, 1'b1));
        pending_items.push_back(rx_item(8'd1, 8'd2, 8'd3, 8'd4, 8'd1, 8'd1, 16'd8, 1'b1));
        pending_items.push_back(rx_item(8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 8'd5, 16'd8, 1'b1));
        pending_items.push_back(rx_item(8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 8'd0, 16'd8, 1'b1));
        pending_items.push_back(rx_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                        16'hFFFF, 1'b1));
        pending_items.push_back(rx_item(8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 8'd1, 16'd8, 1'b0));
        pending_items.push_back(rx_item(8'd1, 8'd2, 8'd3, 8'd255, 8'd3, 8'd4, 16'd64, 1'b1));
        pending_items.push_back(rx_item(8'd1, 8'd9, 8'd3, 8'd7, 8'd0, 8'd1, 16'd0, 1'b1));
        pending_items.push_back(rx_item(8'd5, 8'd0, 8'd3, 8'd1, 8'd0, 8'd1, 16'd0, 1'b1));
        pending_items.push_back(rx_item(8'd6, 8'd7, 8'd3, 8'd0, 8'd0, 8'd2, 16'd10, 1'b1));
        pending_items.push_back(rx_item(8'd0, 8'd7, 8'd0, 8'd1, 8'd0, 8'd1, 16'd10, 1'b1));
        pending_items.push_back(rx_item(8'd255, 8'd255, 8'd255, 8'd1, 8'd0, 8'd1, 16'd1, 1'b1));
        // own key 0:0 already recorded above: seen list stays unchanged
        pending_items.push_back(tx_item(8'd9, 16'd1));
        pending_items.push_back(tx_item(8'd9, 16'd0));
        pending_items.push_back(tx_item(8'd9, 16'd64));
        pending_items.push_back(tx_item(8'd9, 16'd65));
        pending_items.push_back(tx_item(8'd0, 16'd256));
        pending_items.push_back(tx_item(8'd255, 16'd257));
        pending_items.push_back(tx_item(8'd9, 16'hFFFF));
        pending_items.push_back(rx_item(8'd0, 8'd7, 8'd1, 8'd1, 8'd0, 8'd1, 16'd10, 1'b1));
        drain();

        // random phases under several node addresses, extremes included
        foreach (phase_addr[p])
        begin
            write_node(phase_addr[p]);
            for (int i = 0; i < 103; i++)
                pending_items.push_back(random_item(phase_addr[p]));
            drain();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
